// ===== hw/rtl/sfr_pkg.sv =====
// Shared types and constants for the sync frame reassembler.
// Holds the payload structs, the front-to-back command struct and the start-word table.
// No dependencies.
package sfr_pkg;

  localparam logic       OpPush = 1'b0;
  localparam logic       OpRead = 1'b1;

  localparam logic [7:0] SyncB0 = 8'h55;
  localparam logic [7:0] SyncB1 = 8'hAA;
  localparam logic [7:0] SyncB2 = 8'hEB;
  localparam logic [7:0] SyncB3 = 8'h90;

  localparam logic [9:0] RecordLengthReset = 10'd300;
  localparam logic [9:0] MinFrame          = 10'd5;

  // Register index as decoded from paddr[2]
  localparam logic       RegRecordLength = 1'b0;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic [8:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       frame_good;
    logic       frame_dropped;
    logic [9:0] frame_length;
    logic       locked;
  } out_item_t;

  // One classified item on its way to the buffer side
  typedef struct packed {
    logic       wr_en;
    logic [9:0] wr_pos;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [8:0] rd_idx;
    logic       frame_good;
    logic       frame_dropped;
    logic [9:0] frame_length;
    logic       locked;
  } cmd_t;

  function automatic logic [7:0] sync_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = SyncB0;
      2'd1:    b = SyncB1;
      2'd2:    b = SyncB2;
      default: b = SyncB3;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/sfr_fifo.sv =====
// Small register-based FIFO, used for the command queue and the result queue.
// Generic over the entry type; no package dependency.
module sfr_fifo #(
  parameter type T     = logic,
  parameter int  Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  T                           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output T                           data_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/sfr_regs.sv =====
// APB-style configuration register file: holds record_length.
// Depends on sfr_pkg.
module sfr_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [9:0]  record_length_o
);
  import sfr_pkg::*;

  logic [9:0] record_length_q, record_length_d;
  logic       wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == RegRecordLength);

  always_comb begin
    record_length_d = record_length_q;
    if (wr_hit) begin
      record_length_d = pwdata[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_length_q <= RecordLengthReset;
    end else begin
      record_length_q <= record_length_d;
    end
  end

  assign prdata          = (paddr[2] == RegRecordLength) ? 32'(record_length_q) : '0;
  assign record_length_o = record_length_q;

endmodule

// ===== hw/rtl/sfr_front.sv =====
// Front end: takes input beats, tracks start-word hunt and frame collection,
// and turns each beat into a buffer command with its result flags. Depends on sfr_pkg.
module sfr_front #(
  parameter int BufferDepth = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  sfr_pkg::in_item_t item_i,
  input  logic [9:0]       record_length_i,
  output sfr_pkg::cmd_t    cmd_o
);
  import sfr_pkg::*;

  logic [9:0] cnt_q, cnt_d;
  logic       locked_q, locked_d;
  logic [7:0] sum_q, sum_d;
  logic [9:0] cnt_inc;
  logic [7:0] b;
  logic [1:0] pos;
  logic       ok;

  assign b       = item_i.data_byte;
  assign pos     = cnt_q[1:0];
  assign cnt_inc = cnt_q + 10'd1;

  assign ok = (cnt_inc == record_length_i) && (record_length_i >= MinFrame) &&
              (32'(record_length_i) <= BufferDepth) && (sum_q == b);

  always_comb begin
    cnt_d    = cnt_q;
    locked_d = locked_q;
    sum_d    = sum_q;
    cmd_o    = '0;
    cmd_o.wr_data = b;
    cmd_o.rd_idx  = item_i.read_index;
    if (item_i.operation == OpRead) begin
      cmd_o.rd_en = (32'(item_i.read_index) < BufferDepth);
    end else if (!locked_q) begin
      if (b == sync_byte(pos)) begin
        cmd_o.wr_en  = (32'(pos) < BufferDepth);
        cmd_o.wr_pos = 10'(pos);
        sum_d        = sum_q + b;
        cnt_d        = 10'(pos) + 10'd1;
        locked_d     = (pos == 2'd3);
      end else if (b == SyncB0) begin
        // restart the hunt with this byte as the first start-word byte
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_pos = '0;
        sum_d        = SyncB0;
        cnt_d        = 10'd1;
      end else begin
        sum_d = '0;
        cnt_d = '0;
      end
    end else begin
      cmd_o.wr_en  = (32'(cnt_q) < BufferDepth);
      cmd_o.wr_pos = cnt_q;
      sum_d        = sum_q + b;
      cnt_d        = cnt_inc;
      if (cnt_inc >= record_length_i) begin
        cmd_o.frame_good    = ok;
        cmd_o.frame_dropped = !ok;
        cmd_o.frame_length  = ok ? record_length_i : '0;
        cnt_d    = '0;
        sum_d    = '0;
        locked_d = 1'b0;
      end
    end
    cmd_o.locked = locked_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      locked_q <= 1'b0;
      sum_q    <= '0;
    end else if (accept_i) begin
      cnt_q    <= cnt_d;
      locked_q <= locked_d;
      sum_q    <= sum_d;
    end
  end

endmodule

// ===== hw/rtl/sfr_back.sv =====
// Back end: executes buffer commands against the frame buffer memory, registers the
// read data and queues finished results. Depends on sfr_pkg and sfr_fifo.
module sfr_back #(
  parameter int BufferDepth = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfr_pkg::cmd_t     cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output sfr_pkg::out_item_t out_o,
  output logic              empty_o,
  input  logic              pop_i
);
  import sfr_pkg::*;

  localparam int AddrW  = $clog2(BufferDepth);
  localparam int ODepth = 4;
  localparam int OCntW  = $clog2(ODepth + 1);

  logic [7:0]       mem_q [BufferDepth];
  logic [7:0]       rdata_q;
  logic             p_valid_q;
  cmd_t             p_cmd_q;
  out_item_t        res;
  logic [OCntW-1:0] ocount;
  logic             ofull;

  // Take a command only while the result queue has room for it and the one in flight
  assign cmd_pop_o = !cmd_empty_i &&
                     ((OCntW + 1)'(ocount) + (OCntW + 1)'(p_valid_q) < (OCntW + 1)'(ODepth));

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.wr_en) begin
      mem_q[AddrW'(cmd_i.wr_pos)] <= cmd_i.wr_data;
    end
    if (cmd_pop_o && cmd_i.rd_en) begin
      rdata_q <= mem_q[AddrW'(cmd_i.rd_idx)];
    end
    if (cmd_pop_o) begin
      p_cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= cmd_pop_o;
    end
  end

  always_comb begin
    res.read_data     = p_cmd_q.rd_en ? rdata_q : '0;
    res.frame_good    = p_cmd_q.frame_good;
    res.frame_dropped = p_cmd_q.frame_dropped;
    res.frame_length  = p_cmd_q.frame_length;
    res.locked        = p_cmd_q.locked;
  end

  sfr_fifo #(
    .T     (out_item_t),
    .Depth (ODepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (p_valid_q),
    .data_i  (res),
    .full_o  (ofull),
    .pop_i   (pop_i),
    .data_o  (out_o),
    .empty_o (empty_o),
    .count_o (ocount)
  );

endmodule

// ===== hw/rtl/magic_sync_frame_reassembler_top.sv =====
// Sync frame reassembler: hunts a byte stream for the start word 55 AA EB 90, collects
// record_length bytes into a frame buffer and checks the 8-bit additive checksum in the
// last byte. Every input beat, push or read, yields exactly one result beat. The block
// takes one beat per clock cycle while the command queue is not full; a result passes
// through the command queue, then the buffer access, then the result queue before it
// is on the output ports. The buffer has one write and one registered read per cycle,
// which sets that rate. Buffer contents come up undefined: read an entry only after a
// frame_good has covered it.
// Depends on sfr_pkg, sfr_regs, sfr_front, sfr_back and sfr_fifo.
module magic_sync_frame_reassembler_top #(
  parameter int BufferDepth = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sfr_pkg::in_item_t  in_i,
  output logic               empty,
  input  logic               pop,
  output sfr_pkg::out_item_t out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sfr_pkg::*;

  localparam int CDepth = 4;

  logic [9:0]                  record_length;
  logic                        accept;
  cmd_t                        cmd_in, cmd_out;
  logic                        cmd_empty, cmd_pop;
  logic [$clog2(CDepth+1)-1:0] cmd_count;

  assign accept = push && !full;

  sfr_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .record_length_o (record_length)
  );

  sfr_front #(
    .BufferDepth (BufferDepth)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .item_i          (in_i),
    .record_length_i (record_length),
    .cmd_o           (cmd_in)
  );

  sfr_fifo #(
    .T     (cmd_t),
    .Depth (CDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  sfr_back #(
    .BufferDepth (BufferDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_o       (out_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule
